// ===== hdl/sdpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sdpa_pkg;

	localparam int CORDIC_STEPS = 30;
	localparam int COORD_SHIFT  = 16;
	localparam int ROOT_BITS    = 10;
	localparam int RAD_SQ_BITS  = 2 * ROOT_BITS;

	localparam logic [10:0] MAX_STRIP_ROWS = 11'd1024;
	localparam logic [12:0] MAX_STRIP_COLS = 13'd4096;

	localparam logic [10:0] SRC_ROWS_RST     = 11'd512;
	localparam logic [12:0] SRC_COLS_RST     = 13'd1024;
	localparam logic [8:0]  ROTATION_DEG_RST = 9'd180;

	localparam logic [8:0]  DEG_FULL = 9'd360;
	localparam logic [16:0] DEG_HALF = 17'd180;

	// ceil(2^28 / 360), exact floor(x/360) for x < 2^17
	localparam logic [19:0] ROT_RECIP       = 20'd745655;
	localparam int          ROT_RECIP_SHIFT = 28;

	typedef enum logic [1:0] {
		CFG_SRC_ROWS     = 2'd0,
		CFG_SRC_COLS     = 2'd1,
		CFG_ROTATION_DEG = 2'd2
	} cfg_idx_t;

	localparam logic [31:0] TURN_QUARTER  = 32'h4000_0000;
	localparam logic [31:0] TURN_HALF     = 32'h8000_0000;
	localparam logic [31:0] TURN_3QUARTER = 32'hC000_0000;

	// atan(2^-i) as a 32-bit fraction of a turn
	localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] ang;
		logic        axis;
	} cordic_t;

	typedef struct packed {
		logic [RAD_SQ_BITS-1:0] v;
		logic [ROOT_BITS+2:0]   rem;
		logic [ROOT_BITS-1:0]   root;
	} sqrt_t;

	function automatic logic [31:0] coord_scale(input logic [11:0] v);
		return {{(32 - 12 - COORD_SHIFT){v[11]}}, v, {COORD_SHIFT{1'b0}}};
	endfunction

endpackage
`default_nettype wire

// ===== hdl/sdpa_cordic_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sdpa_cordic_cell #(
	parameter int SHIFT = 0,
	parameter int SW    = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  sdpa_pkg::cordic_t vin,
	input  logic [SW-1:0]     sb_in,
	output sdpa_pkg::cordic_t vout,
	output logic [SW-1:0]     sb_out
);
	import sdpa_pkg::*;

	cordic_t            nxt;
	cordic_t            vec_q;
	logic [SW-1:0]      sb_q;
	logic signed [31:0] xs;
	logic signed [31:0] ys;
	logic               go_pos;

	always_comb begin
		xs     = $signed(vin.x) >>> SHIFT;
		ys     = $signed(vin.y) >>> SHIFT;
		go_pos = !vin.y[31] && (vin.y != '0);
		nxt    = vin;
		// axis points already carry their exact angle
		if (!vin.axis) begin
			if (go_pos) begin
				nxt.x   = vin.x + ys;
				nxt.y   = vin.y - xs;
				nxt.ang = vin.ang + ATAN_TURNS[SHIFT];
			end else begin
				nxt.x   = vin.x - ys;
				nxt.y   = vin.y + xs;
				nxt.ang = vin.ang - ATAN_TURNS[SHIFT];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_q <= '0;
		end else if (en) begin
			sb_q <= sb_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_q <= nxt;
		end
	end

	assign vout   = vec_q;
	assign sb_out = sb_q;

endmodule
`default_nettype wire

// ===== hdl/sdpa_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sdpa_sqrt_cell #(
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  sdpa_pkg::sqrt_t vin,
	input  logic [SW-1:0]   sb_in,
	output sdpa_pkg::sqrt_t vout,
	output logic [SW-1:0]   sb_out
);
	import sdpa_pkg::*;

	sqrt_t                nxt;
	sqrt_t                vec_q;
	logic [SW-1:0]        sb_q;
	logic [ROOT_BITS+2:0] rem_sh;
	logic [ROOT_BITS+2:0] trial;

	// one root bit per cell: bring down two bits, try (root*4 + 1)
	always_comb begin
		rem_sh = {vin.rem[ROOT_BITS:0], vin.v[RAD_SQ_BITS-1 -: 2]};
		trial  = {1'b0, vin.root, 2'b01};
		nxt.v  = {vin.v[RAD_SQ_BITS-3:0], 2'b00};
		if (rem_sh >= trial) begin
			nxt.rem  = rem_sh - trial;
			nxt.root = {vin.root[ROOT_BITS-2:0], 1'b1};
		end else begin
			nxt.rem  = rem_sh;
			nxt.root = {vin.root[ROOT_BITS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_q <= '0;
		end else if (en) begin
			sb_q <= sb_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_q <= nxt;
		end
	end

	assign vout   = vec_q;
	assign sb_out = sb_q;

endmodule
`default_nettype wire

// ===== hdl/strip_to_disc_pixel_address.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   | dir | fields (tdata from bit 0)
// s_axis    | in  | out_row[10:0], out_col[21:11]
// m_axis    | out | inside_res[0], strip_row[10:1], strip_col[22:11]
// cfg       | in  | cfg_we, cfg_index, cfg_wdata
//
// One word per clock in and out while the output is not stalled; 2 setup stages,
// 30 CORDIC cells, 10 square-root cells and 1 output register.
// The whole pipeline advances when the output register is empty or taken;
// a stalled output holds every stage and drops s_axis_tready.
// Reset clears the valid bits and loads the register defaults.
module strip_to_disc_pixel_address #(
	parameter int ANGLE_BITS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // out_row, out_col
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // inside_res, strip_row, strip_col
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_wdata
);
	import sdpa_pkg::*;

	localparam logic [63:0] TURN = 64'd1 << ANGLE_BITS;
	localparam logic [ANGLE_BITS-1:0] ROT_Q = ANGLE_BITS'(TURN / 64'd360);
	localparam logic [8:0] ROT_R = 9'(TURN % 64'd360);
	localparam int SW_C = 44 + ANGLE_BITS;
	localparam int SW_S = 15 + ANGLE_BITS;

	logic [10:0] src_rows_q;
	logic [12:0] src_cols_q;
	logic [8:0]  rotation_deg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_rows_q     <= SRC_ROWS_RST;
			src_cols_q     <= SRC_COLS_RST;
			rotation_deg_q <= ROTATION_DEG_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SRC_ROWS:     src_rows_q     <= cfg_wdata[10:0];
				CFG_SRC_COLS:     src_cols_q     <= cfg_wdata;
				CFG_ROTATION_DEG: rotation_deg_q <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	logic        en;
	logic        out_v_q;
	logic [10:0] r_lim;
	logic [12:0] c_lim;
	logic [8:0]  rot_lim;

	assign en            = !out_v_q || m_axis_tready;
	assign s_axis_tready = en;

	assign r_lim   = (src_rows_q > MAX_STRIP_ROWS) ? MAX_STRIP_ROWS : src_rows_q;
	assign c_lim   = (src_cols_q > MAX_STRIP_COLS) ? MAX_STRIP_COLS : src_cols_q;
	assign rot_lim = (rotation_deg_q >= DEG_FULL) ? rotation_deg_q - DEG_FULL : rotation_deg_q;

	// stage 1: offsets from the centre
	logic               v_s1;
	logic signed [11:0] dx_s1;
	logic signed [11:0] dy_s1;
	logic [10:0]        r_s1;
	logic [12:0]        c_s1;
	logic [8:0]         rot_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= $signed({1'b0, s_axis_tdata[21:11]}) - $signed({1'b0, r_lim});
			dy_s1  <= $signed({1'b0, r_lim}) - $signed({1'b0, s_axis_tdata[10:0]});
			r_s1   <= r_lim;
			c_s1   <= c_lim;
			rot_s1 <= rot_lim;
		end
	end

	// stage 2: squares, rotation split, quadrant fold
	logic                  v_s2;
	logic [22:0]           dx2_s2;
	logic [22:0]           dy2_s2;
	logic [20:0]           rsq_s2;
	logic [12:0]           c_s2;
	logic [ANGLE_BITS-1:0] rot_hi_s2;
	logic [16:0]           rot_lo_s2;
	cordic_t               fold;
	cordic_t               fold_s2;

	always_comb begin
		fold.axis = 1'b0;
		fold.ang  = '0;
		fold.x    = coord_scale(dx_s1);
		fold.y    = coord_scale(dy_s1);
		if (dy_s1 == '0) begin
			fold.axis = 1'b1;
			fold.ang  = dx_s1[11] ? TURN_HALF : '0;
		end else if (dx_s1 == '0) begin
			fold.axis = 1'b1;
			fold.ang  = dy_s1[11] ? TURN_3QUARTER : TURN_QUARTER;
		end else if (!dx_s1[11] && !dy_s1[11]) begin
			fold.ang = '0;
		end else if (dx_s1[11] && !dy_s1[11]) begin
			fold.ang = TURN_QUARTER;
			fold.x   = coord_scale(dy_s1);
			fold.y   = coord_scale(-dx_s1);
		end else if (dx_s1[11]) begin
			fold.ang = TURN_HALF;
			fold.x   = coord_scale(-dx_s1);
			fold.y   = coord_scale(-dy_s1);
		end else begin
			fold.ang = TURN_3QUARTER;
			fold.x   = coord_scale(-dy_s1);
			fold.y   = coord_scale(dx_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx2_s2    <= 23'(dx_s1 * dx_s1);
			dy2_s2    <= 23'(dy_s1 * dy_s1);
			rsq_s2    <= 21'(r_s1) * 21'(r_s1);
			c_s2      <= c_s1;
			rot_hi_s2 <= ROT_Q * ANGLE_BITS'(rot_s1);
			rot_lo_s2 <= 17'(rot_s1) * 17'(ROT_R) + DEG_HALF;
			fold_s2   <= fold;
		end
	end

	// radius test and rotation remainder feed the CORDIC row
	logic [23:0]     d2;
	logic            in_disc;
	logic [8:0]      rot_frac;
	logic [36:0]     rot_prod;
	logic [SW_C-1:0] sbc_in;

	assign d2       = 24'(dx2_s2) + 24'(dy2_s2);
	assign in_disc  = (c_s2 != '0) && (d2 < 24'(rsq_s2));
	assign rot_prod = 37'(rot_lo_s2) * 37'(ROT_RECIP);
	assign rot_frac = 9'(rot_prod >> ROT_RECIP_SHIFT);
	assign sbc_in   = {v_s2, in_disc, c_s2, d2[RAD_SQ_BITS-1:0], rot_hi_s2, rot_frac};

	cordic_t         cvec [CORDIC_STEPS+1];
	logic [SW_C-1:0] csb  [CORDIC_STEPS+1];

	assign cvec[0] = fold_s2;
	assign csb[0]  = sbc_in;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		sdpa_cordic_cell #(
			.SHIFT(i),
			.SW   (SW_C)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.vin   (cvec[i]),
			.sb_in (csb[i]),
			.vout  (cvec[i+1]),
			.sb_out(csb[i+1])
		);
	end

	logic                   c_v;
	logic                   c_inside;
	logic [12:0]            c_c;
	logic [RAD_SQ_BITS-1:0] c_d2;
	logic [ANGLE_BITS-1:0]  c_rot_hi;
	logic [8:0]             c_rot_frac;
	logic [ANGLE_BITS-1:0]  phi;
	logic [SW_S-1:0]        sbs_in;
	sqrt_t                  sq_in;

	assign {c_v, c_inside, c_c, c_d2, c_rot_hi, c_rot_frac} = csb[CORDIC_STEPS];
	assign phi = cvec[CORDIC_STEPS].ang[31 -: ANGLE_BITS] + c_rot_hi
		+ ANGLE_BITS'(c_rot_frac);
	assign sbs_in     = {c_v, c_inside, c_c, phi};
	assign sq_in.v    = c_d2;
	assign sq_in.rem  = '0;
	assign sq_in.root = '0;

	sqrt_t           svec [ROOT_BITS+1];
	logic [SW_S-1:0] ssb  [ROOT_BITS+1];

	assign svec[0] = sq_in;
	assign ssb[0]  = sbs_in;

	for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
		sdpa_sqrt_cell #(
			.SW(SW_S)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.vin   (svec[k]),
			.sb_in (ssb[k]),
			.vout  (svec[k+1]),
			.sb_out(ssb[k+1])
		);
	end

	logic                  s_v;
	logic                  s_inside;
	logic [12:0]           s_c;
	logic [ANGLE_BITS-1:0] s_phi;
	logic [ANGLE_BITS+12:0] bin_prod;

	assign {s_v, s_inside, s_c, s_phi} = ssb[ROOT_BITS];
	assign bin_prod = (ANGLE_BITS+13)'(s_phi) * (ANGLE_BITS+13)'(s_c);

	logic        inside_q;
	logic [9:0]  strip_row_q;
	logic [11:0] strip_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= s_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_q    <= s_inside;
			strip_row_q <= s_inside ? svec[ROOT_BITS].root : '0;
			strip_col_q <= s_inside ? 12'(bin_prod >> ANGLE_BITS) : '0;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {1'b0, strip_col_q, strip_row_q, inside_q};

`ifndef SYNTH
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !inside_q) |-> (strip_row_q == '0 && strip_col_q == '0))
		else $error("outside pixel with nonzero address");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> ($stable(v_s1) && $stable(v_s2)))
		else $error("pipeline moved during output stall");

	a_addr_in_strip: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && inside_q) |->
		({1'b0, strip_row_q} < r_lim && {1'b0, strip_col_q} < c_lim))
		else $error("inside address beyond strip");
`endif

endmodule
`default_nettype wire
